// ===== hdl/mfir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfir_pkg: shared types and constants of the multichannel FIR filter
// Sizes of the tap chain, the request codes and the item that walks the
// chain from cell to cell.
// ----------------------------------------------------------------------------
package mfir_pkg;

  localparam int unsigned MaxTaps     = 32;
  localparam int unsigned MaxChannels = 8;

  localparam int unsigned ReqW     = 2;
  localparam int unsigned ChanW    = 3;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned CoefIdxW = 5;
  localparam int unsigned CoefW    = 32;
  localparam int unsigned TapCntW  = 6;
  localparam int unsigned FracBits = 16;

  localparam int unsigned TapIdxW  = (MaxTaps > 1) ? $clog2(MaxTaps) : 1;
  localparam int unsigned ChanIdxW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  localparam int unsigned ProdW    = CoefW + SampleW;
  localparam int unsigned AccW     = ProdW + $clog2(MaxTaps);

  typedef enum logic [ReqW-1:0] {
    ReqSample = 2'd0,
    ReqCoef   = 2'd1,
    ReqFlush  = 2'd2
  } req_e;

  // One item in flight along the tap chain.
  typedef struct packed {
    logic                       valid;
    req_e                       kind;
    logic                       filt;
    logic [ChanW-1:0]           ch;
    logic signed [SampleW-1:0]  x;
    logic signed [SampleW-1:0]  carry;
    logic signed [AccW-1:0]     acc;
    logic signed [ProdW-1:0]    prod;
    logic [CoefIdxW-1:0]        coef_index;
    logic signed [CoefW-1:0]    coef_value;
  } tok_t;

endpackage

// ===== hdl/multichannel_fir_filter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_fir_filter_core: direct-form FIR filter for interleaved PCM
// Each input item is a sample, a coefficient write or a history flush. It
// walks a chain of MaxTaps tap cells, one cell per cycle unless frozen, and
// sample items yield one result item, filtered and saturated if tap_count > 0.
//
// Channels: the input and output channels use valid/ready; an item moves
// when both are high. tap_count is written through cfg_we_i/cfg_data_i; the
// user must write it only while the block is idle (not enforced by the block).
// Path: an accepted item is registered in each tap cell in turn, and a
// sample's result then in the result register. Only a single item
// travels the 32-cell chain at a time; the next item is taken in the
// cycle the previous one leaves the chain. An unused request code is
// accepted and causes nothing.
// Reset: history, coefficients and tap_count clear to zero; a tap count of
// zero passes samples straight through.
// Stall: the result register holds until taken. An item that is already in
// the chain may then finish; a sample waits in the last cell, freezing the
// chain, until the result register is free again.
// ----------------------------------------------------------------------------
module multichannel_fir_filter_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mfir_pkg::TapCntW-1:0]         cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [mfir_pkg::ReqW-1:0]            req_type_i,
  input  logic [mfir_pkg::ChanW-1:0]           channel_i,
  input  logic signed [mfir_pkg::SampleW-1:0]  sample_in_i,
  input  logic [mfir_pkg::CoefIdxW-1:0]        coef_index_i,
  input  logic signed [mfir_pkg::CoefW-1:0]    coef_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [mfir_pkg::SampleW-1:0]  sample_out_o,
  output logic [mfir_pkg::ChanW-1:0]           channel_out_o,
  output logic                                 clipped_o
);

  localparam int unsigned NTaps   = mfir_pkg::MaxTaps;
  localparam int unsigned SampleW = mfir_pkg::SampleW;
  localparam int unsigned AccW    = mfir_pkg::AccW;
  localparam int unsigned FracW   = mfir_pkg::FracBits;
  localparam int unsigned QW      = AccW - FracW;
  localparam logic signed [SampleW-1:0] SatMax = SampleW'((2 ** (SampleW - 1)) - 1);
  localparam logic signed [SampleW-1:0] SatMin = SampleW'(2 ** (SampleW - 1));

  mfir_pkg::tok_t                 chain [NTaps+1];
  mfir_pkg::tok_t                 end_tok;
  logic [NTaps-1:0]               tok_vld;
  logic [mfir_pkg::TapCntW-1:0]   tap_count_q;
  logic                           busy_q, busy_d;
  logic                           launch;
  logic                           adv;
  logic                           end_fire;
  logic                           end_is_sample;

  logic signed [AccW-1:0]         sum;
  logic signed [QW-1:0]           quot;
  logic signed [SampleW-1:0]      y;
  logic                           clip;

  logic                           out_valid_q;
  logic signed [SampleW-1:0]      sample_out_q;
  logic [mfir_pkg::ChanW-1:0]     channel_out_q;
  logic                           clip_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= '0;
    end else if (cfg_we_i) begin
      tap_count_q <= cfg_data_i;
    end
  end

  assign end_tok       = chain[NTaps];
  assign end_is_sample = end_tok.valid && (end_tok.kind == mfir_pkg::ReqSample);
  // Only a finishing sample, meeting a held result, freezes the chain.
  assign adv           = !(end_is_sample && out_valid_q && !out_ready_i);
  assign end_fire      = end_tok.valid && adv;
  assign in_ready_o    = !busy_q || end_fire;

  assign launch = in_valid_i && in_ready_o &&
                  (req_type_i == mfir_pkg::ReqSample ||
                   req_type_i == mfir_pkg::ReqCoef ||
                   req_type_i == mfir_pkg::ReqFlush);

  always_comb begin
    chain[0]            = '0;
    chain[0].valid      = launch;
    chain[0].kind       = mfir_pkg::req_e'(req_type_i);
    chain[0].filt       = (req_type_i == mfir_pkg::ReqSample) &&
                          (tap_count_q != '0) &&
                          (32'(channel_i) < 32'(mfir_pkg::MaxChannels));
    chain[0].ch         = channel_i;
    chain[0].x          = sample_in_i;
    chain[0].carry      = sample_in_i;
    chain[0].coef_index = coef_index_i;
    chain[0].coef_value = coef_value_i;
  end

  for (genvar k = 0; k < NTaps; k++) begin : g_tap
    mfir_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .idx_i       (mfir_pkg::TapIdxW'(k)),
      .tap_count_i (tap_count_q),
      .tok_i       (chain[k]),
      .tok_o       (chain[k+1])
    );
    assign tok_vld[k] = chain[k+1].valid;
  end

  always_comb begin
    busy_d = busy_q;
    if (launch) begin
      busy_d = 1'b1;
    end else if (end_fire) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // Scale by 2^-16 with truncation toward zero, then saturate if filtered.
  always_comb begin
    sum  = $signed(end_tok.acc) + AccW'($signed(end_tok.prod));
    quot = QW'(sum >>> FracW);
    if (sum[AccW-1] && (sum[FracW-1:0] != '0)) begin
      quot = quot + QW'(1);
    end
    clip = 1'b0;
    y    = end_tok.x;
    if (end_tok.filt) begin
      if (quot > QW'(SatMax)) begin
        y    = SatMax;
        clip = 1'b1;
      end else if (quot < QW'(SatMin)) begin
        y    = SatMin;
        clip = 1'b1;
      end else begin
        y = SampleW'(quot);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (end_fire && end_is_sample) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_fire && end_is_sample) begin
      sample_out_q  <= y;
      channel_out_q <= end_tok.ch;
      clip_q        <= clip;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = sample_out_q;
  assign channel_out_o = channel_out_q;
  assign clipped_o     = clip_q;

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one item in the tap chain");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (tok_vld == '0))
    else $error("item in the tap chain while idle");

  a_launch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch |=> busy_q)
    else $error("launched item not tracked as busy");

  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (end_fire && end_is_sample) |=> out_valid_q)
    else $error("finished sample produced no result");

  a_clip_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && clip_q) |-> (sample_out_q == SatMax || sample_out_q == SatMin))
    else $error("clip flag set on an unsaturated result");
`endif

endmodule

// ===== hdl/mfir_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfir_cell: one tap of the FIR chain
// Holds one coefficient and one history slot per channel, multiplies the
// passing sample by its coefficient and hands the item on to the next tap.
// ----------------------------------------------------------------------------
module mfir_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic [mfir_pkg::TapIdxW-1:0]  idx_i,
  input  logic [mfir_pkg::TapCntW-1:0]  tap_count_i,
  input  mfir_pkg::tok_t                tok_i,
  output mfir_pkg::tok_t                tok_o
);

  localparam int unsigned ChW   = mfir_pkg::ChanIdxW;
  localparam int unsigned AccW  = mfir_pkg::AccW;
  localparam int unsigned ProdW = mfir_pkg::ProdW;

  logic signed [mfir_pkg::CoefW-1:0]   coef_q, coef_d;
  logic signed [mfir_pkg::SampleW-1:0] hist_q [mfir_pkg::MaxChannels];
  logic signed [mfir_pkg::SampleW-1:0] hist_d [mfir_pkg::MaxChannels];
  mfir_pkg::tok_t                      tok_q, tok_d;
  logic [ChW-1:0]                      ch_idx;
  logic                                fire;
  logic                                use_tap;

  assign ch_idx  = ChW'(tok_i.ch);
  assign fire    = adv_i && tok_i.valid;
  assign use_tap = tok_i.filt && (32'(idx_i) < 32'(tap_count_i));

  always_comb begin
    tok_d       = tok_i;
    tok_d.acc   = $signed(tok_i.acc) + AccW'($signed(tok_i.prod));
    // Both factors are sign-extended to the full product width.
    tok_d.prod  = '0;
    if (use_tap) begin
      tok_d.prod = ProdW'($signed(coef_q) * $signed(tok_i.carry));
    end
    // The slot held here is the next older sample for the following tap.
    tok_d.carry = hist_q[ch_idx];
  end

  always_comb begin
    hist_d = hist_q;
    if (fire) begin
      if (tok_i.kind == mfir_pkg::ReqFlush) begin
        for (int i = 0; i < int'(mfir_pkg::MaxChannels); i++) begin
          hist_d[i] = '0;
        end
      end else if (tok_i.kind == mfir_pkg::ReqSample && tok_i.filt) begin
        hist_d[ch_idx] = tok_i.carry;
      end
    end
  end

  always_comb begin
    coef_d = coef_q;
    if (fire && tok_i.kind == mfir_pkg::ReqCoef &&
        32'(tok_i.coef_index) == 32'(idx_i)) begin
      coef_d = tok_i.coef_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      coef_q <= '0;
      for (int i = 0; i < int'(mfir_pkg::MaxChannels); i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      coef_q <= coef_d;
      hist_q <= hist_d;
      if (adv_i) begin
        tok_q <= tok_d;
      end
    end
  end

  assign tok_o = tok_q;

endmodule
